// ----- sv/sfr_pkg.sv -----
package sfr_pkg;

  // command codes on the func field
  localparam logic [2:0] FUNC_BOX   = 3'd0;
  localparam logic [2:0] FUNC_CTRI  = 3'd1;
  localparam logic [2:0] FUNC_RTRI  = 3'd2;
  localparam logic [2:0] FUNC_HLINE = 3'd3;
  localparam logic [2:0] FUNC_VLINE = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  // work kinds after classification
  localparam logic [2:0] KIND_BOX  = 3'd0;
  localparam logic [2:0] KIND_CTRI = 3'd1;
  localparam logic [2:0] KIND_RTRI = 3'd2;
  localparam logic [2:0] KIND_READ = 3'd3;
  localparam logic [2:0] KIND_NONE = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_DRAWN  = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_READ   = 2'd2;

  // configuration register indexes
  localparam logic REG_ACTIVE_WIDTH  = 1'b0;
  localparam logic REG_ACTIVE_HEIGHT = 1'b1;

  localparam logic [6:0] ACTIVE_RESET = 7'd64;

  // field widths
  localparam int POS_W   = 6;
  localparam int LEN_W   = 7;
  localparam int COLOR_W = 8;
  localparam int NUM_W   = 14;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [LEN_W-1:0]   w;
    logic [LEN_W-1:0]   h;
    logic [COLOR_W-1:0] color;
  } cmd_entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [LEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- sv/sfr_channels.sv -----
interface sfr_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [5:0] pos_x;
  logic [5:0] pos_y;
  logic [6:0] span_w;
  logic [6:0] span_h;
  logic [7:0] color;

  modport source (output valid, func, pos_x, pos_y, span_w, span_h, color, input ready);
  modport sink (input valid, func, pos_x, pos_y, span_w, span_h, color, output ready);
endinterface

interface sfr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] pixel;

  modport source (output valid, status, pixel, input ready);
  modport sink (input valid, status, pixel, output ready);
endinterface

// ----- sv/sfr_queue.sv -----
module sfr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sfr_pkg::cmd_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output sfr_pkg::cmd_entry_t head,
  output logic               empty
);
  import sfr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_entry_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/sfr_front.sv -----
module sfr_front #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_index,
  input  logic [6:0]          cfg_wr_data,
  input  logic                clearing,
  sfr_cmd_if.sink             cmd,
  output logic                push,
  output sfr_pkg::cmd_entry_t push_entry,
  input  logic                full
);
  import sfr_pkg::*;

  localparam int WCAP = (FRAME_WIDTH < 127) ? FRAME_WIDTH : 127;
  localparam int HCAP = (FRAME_HEIGHT < 127) ? FRAME_HEIGHT : 127;

  logic [LEN_W-1:0] active_width;
  logic [LEN_W-1:0] active_height;
  logic [LEN_W-1:0] aw;
  logic [LEN_W-1:0] ah;
  logic             shape_ok;
  logic [LEN_W-1:0] px;
  logic [LEN_W-1:0] py;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= ACTIVE_RESET;
      active_height <= ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        REG_ACTIVE_WIDTH:  active_width  <= cfg_wr_data;
        REG_ACTIVE_HEIGHT: active_height <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // active size clamped to the frame
  assign aw = (active_width > LEN_W'(WCAP)) ? LEN_W'(WCAP) : active_width;
  assign ah = (active_height > LEN_W'(HCAP)) ? LEN_W'(HCAP) : active_height;

  assign px = {1'b0, cmd.pos_x};
  assign py = {1'b0, cmd.pos_y};

  assign shape_ok = ((8'(cmd.pos_x) + 8'(cmd.span_w)) < 8'(aw)) &&
                    ((8'(cmd.pos_y) + 8'(cmd.span_h)) < 8'(ah));

  // classify: lines become boxes one pixel thick across the active size, failures carry no work
  always_comb begin
    push_entry       = '0;
    push_entry.kind  = KIND_NONE;
    push_entry.x     = cmd.pos_x;
    push_entry.y     = cmd.pos_y;
    push_entry.w     = cmd.span_w;
    push_entry.h     = cmd.span_h;
    push_entry.color = cmd.color;
    unique case (cmd.func)
      FUNC_BOX: begin
        if (shape_ok) push_entry.kind = KIND_BOX;
      end
      FUNC_CTRI: begin
        if (shape_ok) push_entry.kind = KIND_CTRI;
      end
      FUNC_RTRI: begin
        if (shape_ok) push_entry.kind = KIND_RTRI;
      end
      FUNC_HLINE: begin
        if (py < ah) begin
          push_entry.kind = KIND_BOX;
          push_entry.x    = '0;
          push_entry.w    = aw;
          push_entry.h    = LEN_W'(1);
        end
      end
      FUNC_VLINE: begin
        if (px < aw) begin
          push_entry.kind = KIND_BOX;
          push_entry.y    = '0;
          push_entry.w    = LEN_W'(1);
          push_entry.h    = ah;
        end
      end
      FUNC_READ: begin
        if (px < aw && py < ah) push_entry.kind = KIND_READ;
      end
      default: push_entry.kind = KIND_NONE;
    endcase
  end

  assign cmd.ready = !clearing && !full;
  assign push      = cmd.valid && cmd.ready;

endmodule

// ----- sv/sfr_div.sv -----
module sfr_div (
  input  logic              clk,
  input  logic              rst,
  input  sfr_pkg::div_req_t req,
  output sfr_pkg::div_rsp_t rsp
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [LEN_W:0]   shifted;
  logic             qbit;
  logic [LEN_W-1:0] rem_next;

  // one restoring step per cycle
  assign shifted  = {rem, quo[NUM_W-1]};
  assign qbit     = (shifted >= {1'b0, den});
  assign rem_next = qbit ? LEN_W'(shifted - {1'b0, den}) : shifted[LEN_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], qbit};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo[LEN_W-1:0];

endmodule

// ----- sv/sfr_back.sv -----
module sfr_back #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64,
  parameter int COLOR_BITS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  sfr_pkg::cmd_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                clearing,
  output sfr_pkg::div_req_t   div_req,
  input  sfr_pkg::div_rsp_t   div_rsp,
  sfr_res_if.source           res
);
  import sfr_pkg::*;

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (COLOR_BITS < COLOR_W) ? COLOR_BITS : COLOR_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_ROW    = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]            state;
  logic [AW-1:0]         clr_addr;
  logic [2:0]            kind;
  logic [POS_W-1:0]      x;
  logic [POS_W-1:0]      y;
  logic [LEN_W-1:0]      w;
  logic [LEN_W-1:0]      h;
  logic [COLOR_W-1:0]    color;
  logic [LEN_W-1:0]      dy;
  logic [LEN_W-1:0]      dx;
  logic [LEN_W-1:0]      amt;
  logic [LEN_W-1:0]      start;
  logic [NUM_W-1:0]      num;
  logic                  res_valid;
  logic [1:0]            res_status;
  logic [COLOR_W-1:0]    res_pixel;
  logic [COLOR_BITS-1:0] mem [DEPTH];
  logic [COLOR_BITS-1:0] rdata;
  logic [COLOR_BITS-1:0] wdata;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         draw_addr;
  logic [LEN_W-1:0]      col;
  logic [LEN_W-1:0]      row;
  logic                  we;
  logic                  slot_free;
  logic [1:0]            fin_status;
  logic [COLOR_W-1:0]    fin_pixel;

  assign clearing  = (state == ST_CLEAR);
  assign pop       = (state == ST_IDLE) && !empty;
  assign slot_free = !res_valid || res.ready;

  // pixel address of the current span position
  assign col       = LEN_W'({1'b0, x}) + start + dx;
  assign row       = LEN_W'({1'b0, y}) + dy;
  assign draw_addr = AW'(32'(row) * FRAME_WIDTH + 32'(col));
  assign raddr     = AW'(32'({1'b0, y}) * FRAME_WIDTH + 32'({1'b0, x}));

  // write port: clearing sweep or span fill
  always_comb begin
    wdata = '0;
    if (!clearing) begin
      wdata[PW-1:0] = color[PW-1:0];
    end
  end
  assign we    = clearing || ((state == ST_ROW) && (dx < amt));
  assign waddr = clearing ? clr_addr : draw_addr;

  // frame store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // divider launch for the current row
  assign div_req.start = (state == ST_DSTART);
  assign div_req.num   = num;
  assign div_req.den   = h;

  // result fields
  always_comb begin
    fin_pixel  = '0;
    fin_status = STATUS_DRAWN;
    if (kind == KIND_NONE) begin
      fin_status = STATUS_REJECT;
    end else if (kind == KIND_READ) begin
      fin_status         = STATUS_READ;
      fin_pixel[PW-1:0]  = rdata[PW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!empty) begin
            if (head.kind == KIND_NONE) begin
              state <= ST_FINISH;
            end else if (head.kind == KIND_READ) begin
              state <= ST_READ;
            end else if (head.h == '0) begin
              state <= ST_FINISH;
            end else if (head.kind == KIND_BOX) begin
              state <= ST_ROW;
            end else begin
              state <= ST_DSTART;
            end
          end
        end
        ST_DSTART: state <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) state <= ST_ROW;
        end
        ST_ROW: begin
          if (dx >= amt) begin
            if ((dy + LEN_W'(1)) == h) begin
              state <= ST_FINISH;
            end else if (kind != KIND_BOX) begin
              state <= ST_DSTART;
            end
          end
        end
        ST_READ: state <= ST_FINISH;
        ST_FINISH: begin
          if (slot_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (pop) begin
      kind  <= head.kind;
      x     <= head.x;
      y     <= head.y;
      w     <= head.w;
      h     <= head.h;
      color <= head.color;
      dy    <= '0;
      dx    <= '0;
      amt   <= head.w;
      start <= '0;
      num   <= NUM_W'(head.w);
    end else if (state == ST_DIV && div_rsp.done) begin
      amt   <= div_rsp.quot;
      start <= (kind == KIND_CTRI) ? (w >> 1) - (div_rsp.quot >> 1) : '0;
    end else if (state == ST_ROW) begin
      if (dx < amt) begin
        dx <= dx + LEN_W'(1);
      end else begin
        dx  <= '0;
        dy  <= dy + LEN_W'(1);
        num <= num + NUM_W'(w);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINISH && slot_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && slot_free) begin
      res_status <= fin_status;
      res_pixel  <= fin_pixel;
    end
  end

  assign res.valid  = res_valid;
  assign res.status = res_status;
  assign res.pixel  = res_pixel;

  // no command leaves the queue during the clearing sweep
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("command popped during clearing sweep");

  // frame writes come only from the sweep or a span fill
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_CLEAR || state == ST_ROW))
    else $error("frame write outside sweep or fill");

  // every write lands inside the frame
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (32'(waddr) < DEPTH))
    else $error("frame write out of range");

  // a result appears only after a finished command
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_FINISH))
    else $error("result posted without a finished command");

endmodule

// ----- sv/shape_fill_rasterizer.sv -----
// channel   dir  handshake           payload
// cmd       in   cmd.valid/ready     func, pos_x, pos_y, span_w, span_h, color
// res       out  res.valid/ready     status, pixel
// cfg       in   cfg_wr_en           cfg_wr_index, cfg_wr_data (no read-back)
//
// after reset a sweep zeroes all FRAME_WIDTH*FRAME_HEIGHT pixels, one a cycle, with
// cmd.ready low throughout; configuration writes are taken at any time
// a box is filled row by row, one pixel per cycle, between its pop and the posting of its result
// a triangle runs the bit-serial row-span divider before each of its rows
// a read goes via ST_READ to ST_FINISH, a rejected or zero-height command straight to ST_FINISH
// the four-entry command queue and the result register let cmd and res stall independently
module shape_fill_rasterizer #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64,
  parameter int COLOR_BITS   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_index,
  input  logic [6:0] cfg_wr_data,
  sfr_cmd_if.sink    cmd,
  sfr_res_if.source  res
);
  import sfr_pkg::*;

  logic       push;
  cmd_entry_t push_entry;
  logic       full;
  logic       pop;
  cmd_entry_t head;
  logic       empty;
  logic       clearing;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  // accept and classify
  sfr_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data),
    .clearing     (clearing),
    .cmd          (cmd),
    .push         (push),
    .push_entry   (push_entry),
    .full         (full)
  );

  // decoupling queue
  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  // row span divider
  sfr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // raster sequencer and frame store
  sfr_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .COLOR_BITS   (COLOR_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .clearing (clearing),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .res      (res)
  );

endmodule
